FILE: src/ntc_pkg.sv
// Shared types, constants and helpers for the NTC thermistor thermometer.
`default_nettype none

package ntc_pkg;

  localparam int WINDOW_SIZE_DEF = 8;
  localparam int ADC_BITS_DEF    = 10;

  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int TEMP_W    = 15;
  localparam int RES_W     = 20;
  localparam int BETA_W    = 14;
  localparam int OUT_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOM_TEMP   = 2'd0,
    REG_NOM_RES    = 2'd1,
    REG_BETA       = 2'd2,
    REG_SERIES_RES = 2'd3
  } cfg_reg_t;

  localparam logic signed [TEMP_W-1:0] NOM_TEMP_RST   = 15'sd2500;
  localparam logic        [RES_W-1:0]  NOM_RES_RST    = 20'd10000;
  localparam logic        [BETA_W-1:0] BETA_RST       = 14'd4200;
  localparam logic        [RES_W-1:0]  SERIES_RES_RST = 20'd10000;

  // log2 unit: Q30 mantissa, Q24 result with a 5-bit integer part
  localparam int LOG_IN_W  = 31;
  localparam int LOG_FRAC  = 24;
  localparam int LOG_OUT_W = 29;

  // shared long divider width in the back end
  localparam int DIV_W = 48;

  localparam logic [31:0]      LN2_Q32      = 32'd2977044472;
  localparam logic [DIV_W-1:0] SCALE_Q40    = 48'd100 << 40;
  localparam logic [16:0]      KELVIN_CENTI = 17'd27315;

  localparam logic signed [OUT_W-1:0] TEMP_MAX = 16'sh7FFF;
  localparam logic signed [OUT_W-1:0] TEMP_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [TEMP_W-1:0] nom_temp;
    logic        [RES_W-1:0]  nom_res;
    logic        [BETA_W-1:0] beta;
    logic        [RES_W-1:0]  series_res;
  } cfg_t;

  function automatic logic [RES_W-1:0] at_least_one(input logic [RES_W-1:0] v);
    return (v == '0) ? RES_W'(1) : v;
  endfunction

endpackage

`default_nettype wire

FILE: src/ntc_div.sv
// Restoring long divider, one quotient bit per cycle.
`default_nettype none

module ntc_div
  import ntc_pkg::*;
#(
  parameter int W = DIV_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic         done
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     dvd;
  logic [W-1:0]     dsr;
  logic [W-1:0]     quo;
  logic [W-1:0]     rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [W:0]       trial;
  logic             ge;

  assign trial = {rem, dvd[W-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      dvd  <= dividend;
      dsr  <= divisor;
      rem  <= '0;
      cnt  <= CNT_W'(W);
    end else if (busy) begin
      rem <= ge ? W'(trial - {1'b0, dsr}) : W'(trial);
      quo <= {quo[W-2:0], ge};
      dvd <= dvd << 1;
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

FILE: src/ntc_log2.sv
// Iterative log2 unit: normalize one bit a cycle, then 24 squaring steps.
`default_nettype none

module ntc_log2
  import ntc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [LOG_IN_W-1:0]  x,
  output logic [LOG_OUT_W-1:0] result,
  output logic                 done
);

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ} lstate_t;

  lstate_t                   state;
  logic [LOG_IN_W-1:0]       m;
  logic [4:0]                p;
  logic [LOG_FRAC-1:0]       frac;
  logic [4:0]                step;
  logic [2*LOG_IN_W-1:0]     sq;
  logic [LOG_IN_W:0]         s;

  assign sq = (2*LOG_IN_W)'(m) * (2*LOG_IN_W)'(m);
  assign s  = sq[2*LOG_IN_W-1:LOG_IN_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else if (start) begin
      state <= L_NORM;
      done  <= 1'b0;
      m     <= x;
      p     <= 5'(LOG_IN_W - 1);
    end else begin
      case (state)
        L_NORM: begin
          if (m[LOG_IN_W-1]) begin
            state <= L_SQ;
            step  <= '0;
          end else begin
            m <= m << 1;
            p <= p - 5'd1;
          end
        end
        L_SQ: begin
          m    <= s[LOG_IN_W] ? s[LOG_IN_W:1] : s[LOG_IN_W-1:0];
          frac <= {frac[LOG_FRAC-2:0], s[LOG_IN_W]};
          step <= step + 5'd1;
          if (step == 5'(LOG_FRAC - 1)) begin
            state <= L_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign result = {p, frac};

  a_log_pos_input: assert property (@(posedge clk) disable iff (rst)
    start |-> x != '0)
    else $error("log2 started on zero");

endmodule

`default_nettype wire

FILE: src/ntc_queue.sv
// Two-entry queue of window sums between front and back end.
`default_nettype none

module ntc_queue
  import ntc_pkg::*;
#(
  parameter int W = 13
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         nonempty
);

  logic [W-1:0] slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= push_data;
        wr_ptr       <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign full     = count == 2'd2;
  assign nonempty = count != 2'd0;
  assign pop_data = slot[rd_ptr];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("queue overflow");

endmodule

`default_nettype wire

FILE: src/ntc_front.sv
// Front end: sample window, running sum, refill after reset and config writes.
`default_nettype none

module ntc_front
  import ntc_pkg::*;
#(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
  parameter int ADC_BITS    = ADC_BITS_DEF,
  parameter int SUM_W       = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                cfg_hit,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ADC_BITS-1:0] adc_sample,
  output logic                push,
  output logic [SUM_W-1:0]    push_sum,
  input  logic                q_full
);

  typedef enum logic [1:0] {F_START, F_WAIT, F_RUN} fstate_t;

  localparam int DVD_W = ADC_BITS + RES_W + 1;
  localparam logic [SUM_W-1:0] TOP = SUM_W'((2**ADC_BITS - 1) * WINDOW_SIZE);
  localparam logic [ADC_BITS-1:0] FULL_CODE = {ADC_BITS{1'b1}};

  fstate_t             state;
  logic [ADC_BITS-1:0] taps [WINDOW_SIZE];
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    sum_next;
  logic                accept;
  logic [RES_W-1:0]    r0;
  logic [RES_W-1:0]    rs;
  logic                div_start;
  logic [DVD_W-1:0]    div_a;
  logic [DVD_W-1:0]    div_b;
  logic [DVD_W-1:0]    div_q;
  logic                div_done;
  logic [ADC_BITS-1:0] fill_code;

  assign r0        = at_least_one(cfg.nom_res);
  assign rs        = at_least_one(cfg.series_res);
  assign fill_code = div_q[ADC_BITS-1:0];

  assign in_stall = (state != F_RUN) || q_full;
  assign accept   = in_valid && !in_stall;
  assign sum_next = sum - SUM_W'(taps[WINDOW_SIZE-1]) + SUM_W'(adc_sample);
  assign push     = accept;
  assign push_sum = sum_next;

  ntc_div #(.W(DVD_W)) u_fill_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (div_q),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    if (rst) begin
      state <= F_START;
    end else if (cfg_hit) begin
      state <= F_START;
    end else begin
      case (state)
        F_START: begin
          div_start <= 1'b1;
          div_a     <= DVD_W'(FULL_CODE) * DVD_W'(r0);
          div_b     <= DVD_W'(rs) + DVD_W'(r0);
          state     <= F_WAIT;
        end
        F_WAIT: begin
          if (!div_start && div_done) begin
            for (int i = 0; i < WINDOW_SIZE; i++) begin
              taps[i] <= fill_code;
            end
            sum   <= SUM_W'(fill_code) * SUM_W'(WINDOW_SIZE);
            state <= F_RUN;
          end
        end
        F_RUN: begin
          if (accept) begin
            taps[0] <= adc_sample;
            for (int i = 1; i < WINDOW_SIZE; i++) begin
              taps[i] <= taps[i-1];
            end
            sum <= sum_next;
          end
        end
        default: state <= F_START;
      endcase
    end
  end

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    state == F_RUN |-> sum <= TOP)
    else $error("window sum beyond full scale");

endmodule

`default_nettype wire

FILE: src/ntc_back.sv
// Back end: log ratio, beta equation, reciprocal and result register.
`default_nettype none

module ntc_back
  import ntc_pkg::*;
#(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
  parameter int ADC_BITS    = ADC_BITS_DEF,
  parameter int SUM_W       = 13
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    cfg_hit,
  input  logic                    q_nonempty,
  input  logic [SUM_W-1:0]        q_data,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] temperature_centi,
  output logic                    out_of_range
);

  typedef enum logic [3:0] {
    B_IDLE, B_CLOG, B_CDIV, B_ILOG, B_MUL, B_TGO, B_TDIV, B_RDIV, B_FIN
  } bstate_t;

  localparam logic [SUM_W-1:0] TOP = SUM_W'((2**ADC_BITS - 1) * WINDOW_SIZE);
  localparam logic [DIV_W-1:0] TK_HIGH = DIV_W'(60082);

  bstate_t                 state;
  logic                    const_ok;
  logic signed [LOG_OUT_W:0] lconst;
  logic [DIV_W-1:0]        qinv;
  logic                    lneg;
  logic [30:0]             labs;
  logic [62:0]             prod;
  logic signed [OUT_W-1:0] res_temp;
  logic                    res_flag;

  logic                    log_start;
  logic [LOG_IN_W-1:0]     log_a_x;
  logic [LOG_IN_W-1:0]     log_b_x;
  logic [LOG_OUT_W-1:0]    log_a_res;
  logic [LOG_OUT_W-1:0]    log_b_res;
  logic                    log_a_done;
  logic                    log_b_done;
  logic                    log_ready;

  logic                    div_start;
  logic [DIV_W-1:0]        div_a;
  logic [DIV_W-1:0]        div_b;
  logic [DIV_W-1:0]        div_q;
  logic                    div_done;
  logic                    div_ready;

  logic signed [31:0]      l_sum;
  logic signed [DIV_W:0]   term2;
  logic signed [DIV_W:0]   y;
  logic                    y_pos;
  logic signed [16:0]      t0;
  logic                    out_free;

  assign log_ready = !log_start && log_a_done && log_b_done;
  assign div_ready = !div_start && div_done;
  assign pop       = (state == B_IDLE) && const_ok && q_nonempty;
  assign out_free  = !out_valid || !out_stall;

  assign l_sum = 32'(lconst) + $signed({3'b0, log_a_res}) - $signed({3'b0, log_b_res});
  assign term2 = lneg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign y     = $signed({1'b0, qinv}) + term2;
  assign y_pos = !y[DIV_W] && (y != '0);
  assign t0    = $signed(17'($signed(cfg.nom_temp))) + $signed(KELVIN_CENTI);

  ntc_log2 u_log_a (
    .clk(clk), .rst(rst), .start(log_start), .x(log_a_x),
    .result(log_a_res), .done(log_a_done)
  );

  ntc_log2 u_log_b (
    .clk(clk), .rst(rst), .start(log_start), .x(log_b_x),
    .result(log_b_res), .done(log_b_done)
  );

  ntc_div #(.W(DIV_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor(div_b), .quotient(div_q), .done(div_done)
  );

  always_ff @(posedge clk) begin
    log_start <= 1'b0;
    div_start <= 1'b0;
    if (rst) begin
      state     <= B_IDLE;
      const_ok  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_hit) begin
        const_ok <= 1'b0;
      end
      if (state == B_FIN && out_free) begin
        out_valid         <= 1'b1;
        temperature_centi <= res_temp;
        out_of_range      <= res_flag;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!const_ok && !cfg_hit) begin
            log_start <= 1'b1;
            log_a_x   <= LOG_IN_W'(at_least_one(cfg.series_res));
            log_b_x   <= LOG_IN_W'(at_least_one(cfg.nom_res));
            state     <= B_CLOG;
          end else if (pop) begin
            if (q_data == '0) begin
              res_temp <= TEMP_MAX;
              res_flag <= 1'b1;
              state    <= B_FIN;
            end else if (q_data >= TOP) begin
              res_temp <= TEMP_MIN;
              res_flag <= 1'b1;
              state    <= B_FIN;
            end else begin
              log_start <= 1'b1;
              log_a_x   <= LOG_IN_W'(q_data);
              log_b_x   <= LOG_IN_W'(TOP - q_data);
              state     <= B_ILOG;
            end
          end
        end
        B_CLOG: begin
          // drop constants built from registers that just changed
          if (cfg_hit) begin
            state <= B_IDLE;
          end else if (log_ready) begin
            lconst    <= $signed({1'b0, log_a_res}) - $signed({1'b0, log_b_res});
            div_start <= 1'b1;
            div_a     <= SCALE_Q40;
            div_b     <= DIV_W'($unsigned(t0));
            state     <= B_CDIV;
          end
        end
        B_CDIV: begin
          if (cfg_hit) begin
            state <= B_IDLE;
          end else if (div_ready) begin
            qinv     <= div_q;
            const_ok <= 1'b1;
            state    <= B_IDLE;
          end
        end
        B_ILOG: begin
          if (log_ready) begin
            lneg  <= l_sum[31];
            labs  <= 31'(l_sum[31] ? -l_sum : l_sum);
            state <= B_MUL;
          end
        end
        B_MUL: begin
          prod  <= 63'(labs) * 63'(LN2_Q32);
          state <= B_TGO;
        end
        B_TGO: begin
          div_start <= 1'b1;
          div_a     <= DIV_W'(prod[62:16]);
          div_b     <= DIV_W'(at_least_one(RES_W'(cfg.beta)));
          state     <= B_TDIV;
        end
        B_TDIV: begin
          if (div_ready) begin
            if (!y_pos) begin
              res_temp <= TEMP_MAX;
              res_flag <= 1'b1;
              state    <= B_FIN;
            end else begin
              div_start <= 1'b1;
              div_a     <= SCALE_Q40 + {1'b0, y[DIV_W-1:1]};
              div_b     <= y[DIV_W-1:0];
              state     <= B_RDIV;
            end
          end
        end
        B_RDIV: begin
          if (div_ready) begin
            if (div_q > TK_HIGH) begin
              res_temp <= TEMP_MAX;
              res_flag <= 1'b1;
            end else begin
              res_temp <= $signed(OUT_W'(div_q[16:0] - KELVIN_CENTI));
              res_flag <= 1'b0;
            end
            state <= B_FIN;
          end
        end
        B_FIN: begin
          if (out_free) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_const_ready: assert property (@(posedge clk) disable iff (rst)
    state == B_ILOG |-> const_ok)
    else $error("item started before constants were ready");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state != B_IDLE)
    else $error("popped item was dropped");

endmodule

`default_nettype wire

FILE: src/ntc_thermistor_temperature_top.sv
// Top level of the NTC thermistor thermometer with moving-average window.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid / in_stall       adc_sample
//   out      output     out_valid / out_stall     temperature_centi, out_of_range
//   cfg      input      cfg_write                 cfg_index, cfg_data
//
// In the back end an item passes through the two parallel log2 units
// (bit-serial normalize plus 24 squarings), the ln2 multiply, and up to
// two passes of the shared 48-bit divider. After reset or any config write
// the front refills the window through its own divider with in_stall high,
// and the first item after that also waits while the back end computes the
// fixed log and 1/T0 terms. Up to two window sums queue between front and
// back, and a finished result waits in the output register while the next
// one runs.
`default_nettype none

module ntc_thermistor_temperature_top
  import ntc_pkg::*;
#(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
  parameter int ADC_BITS    = ADC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [ADC_BITS-1:0]     adc_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] temperature_centi,
  output logic                    out_of_range,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  // holds every sum up to WINDOW_SIZE times full scale
  localparam int SUM_W = ADC_BITS + $clog2(WINDOW_SIZE + 1);

  cfg_t             cfg;
  logic             push;
  logic [SUM_W-1:0] push_sum;
  logic             q_full;
  logic             pop;
  logic [SUM_W-1:0] q_data;
  logic             q_nonempty;

  // Configuration registers; every write index is a real register, and
  // each write also restarts the window refill in the front end.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nom_temp   <= NOM_TEMP_RST;
      cfg.nom_res    <= NOM_RES_RST;
      cfg.beta       <= BETA_RST;
      cfg.series_res <= SERIES_RES_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_NOM_TEMP:   cfg.nom_temp   <= $signed(cfg_data[TEMP_W-1:0]);
        REG_NOM_RES:    cfg.nom_res    <= cfg_data[RES_W-1:0];
        REG_BETA:       cfg.beta       <= cfg_data[BETA_W-1:0];
        REG_SERIES_RES: cfg.series_res <= cfg_data[RES_W-1:0];
        default:        cfg.nom_temp   <= cfg.nom_temp;
      endcase
    end
  end

  // Front: accept a request, update the window and push the new sum.
  ntc_front #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .ADC_BITS    (ADC_BITS),
    .SUM_W       (SUM_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cfg_hit    (cfg_write),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .adc_sample (adc_sample),
    .push       (push),
    .push_sum   (push_sum),
    .q_full     (q_full)
  );

  // Decouple the fast front from the long back-end computation.
  ntc_queue #(.W(SUM_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_sum),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .nonempty  (q_nonempty)
  );

  // Back: turn the window sum into a temperature and hold the result.
  ntc_back #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .ADC_BITS    (ADC_BITS),
    .SUM_W       (SUM_W)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .cfg_hit           (cfg_write),
    .q_nonempty        (q_nonempty),
    .q_data            (q_data),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .temperature_centi (temperature_centi),
    .out_of_range      (out_of_range)
  );

endmodule

`default_nettype wire

FILE: sim/ntc_thermistor_temperature_top_tb.sv
// Self-checking testbench for the NTC thermistor thermometer top level.
`default_nettype none

module ntc_thermistor_temperature_top_tb;
  import ntc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN        = WINDOW_SIZE_DEF;
  localparam int FULL       = (1 << ADC_BITS_DEF) - 1;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_WAIT = 400;
  localparam int HOLD_LEN   = 1500;
  localparam longint LN2    = 64'd2977044472;
  localparam longint SCALE  = 64'd100 << 40;
  localparam longint KC     = 27315;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [ADC_BITS_DEF-1:0] adc_sample;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [OUT_W-1:0] temperature_centi;
  logic                    out_of_range;
  logic                    cfg_write;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_data;

  ntc_thermistor_temperature_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .adc_sample(adc_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .temperature_centi(temperature_centi), .out_of_range(out_of_range),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    logic signed [OUT_W-1:0] temp;
    logic                    flag;
  } reading_t;

  // Mirror of the block: registers, sample window, running sum, write slot.
  int              mir_t0;
  longint unsigned mir_r0, mir_beta, mir_rs;
  int              window_codes [WIN];
  longint unsigned window_total;
  int              slot;

  reading_t expected_readings [$];
  int       mismatches;
  int       idle_pct, stall_pct;
  bit       hold_request;
  bit       any_accept;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned floor_one(longint unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  // Truncated Q24 log2 by repeated squaring of a Q30 mantissa.
  function automatic longint log2_q24(longint unsigned x);
    int              p;
    longint unsigned m;
    longint          acc;
    p = 63;
    while (p > 0 && x[p] == 1'b0) p--;
    m = (p <= 30) ? (x << (30 - p)) : (x >> (p - 30));
    acc = longint'(p) << 24;
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        acc += longint'(1) << i;
      end
    end
    return acc;
  endfunction

  function automatic void refill_window();
    longint unsigned r0, rs, code;
    r0 = floor_one(mir_r0);
    rs = floor_one(mir_rs);
    code = (FULL * r0) / (rs + r0);
    for (int i = 0; i < WIN; i++) window_codes[i] = int'(code);
    window_total = code * WIN;
    slot = 0;
  endfunction

  // Push one code through the window and compute the averaged temperature.
  function automatic reading_t average_temperature(int code);
    reading_t        r;
    longint unsigned top;
    longint          l, y, tk, t;
    top = longint'(FULL) * WIN;
    window_total = window_total - window_codes[slot] + code;
    window_codes[slot] = code;
    slot = (slot + 1) % WIN;
    r.flag = 1'b0;
    if (window_total == 0) begin
      t = 32767;
      r.flag = 1'b1;
    end else if (window_total >= top) begin
      t = -32768;
      r.flag = 1'b1;
    end else begin
      l = log2_q24(floor_one(mir_rs)) + log2_q24(window_total)
        - log2_q24(floor_one(mir_r0)) - log2_q24(top - window_total);
      y = SCALE / (longint'(mir_t0) + KC)
        + (l * LN2) / (longint'(floor_one(mir_beta)) << 16);
      if (y <= 0) begin
        t = 32767;
        r.flag = 1'b1;
      end else begin
        tk = (SCALE + y / 2) / y;
        t = tk - KC;
        if (t > 32767) begin
          t = 32767;
          r.flag = 1'b1;
        end else if (t < -32768) begin
          t = -32768;
          r.flag = 1'b1;
        end
      end
    end
    r.temp = t[OUT_W-1:0];
    return r;
  endfunction

  // Watchdog: end the run when nothing moves for too long.
  int quiet_cycles;
  always @(posedge clk) begin
    if (rst || any_accept || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("ntc_thermistor_temperature_top verification failed");
        $finish;
      end
    end
  end

  // Result checker: compare each accepted reading with the oldest expectation.
  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reading: temp %0d flag %0d", temperature_centi, out_of_range);
      end else begin
        want = expected_readings.pop_front();
        if (want.temp !== temperature_centi || want.flag !== out_of_range) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reading mismatch: expected temp %0d flag %0d, got temp %0d flag %0d",
                     want.temp, want.flag, temperature_centi, out_of_range);
        end
      end
    end
  end

  // Receiver: stall at random, or hold off for a long stretch when asked.
  initial begin
    int hold_left;
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_LEN;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one request; idle first at the configured rate, then wait for acceptance.
  task automatic send_code(input int code, input bit typed, input reading_t typed_val);
    reading_t pred;
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    adc_sample = code[ADC_BITS_DEF-1:0];
    do @(posedge clk); while (in_stall);
    pred = average_temperature(code);
    expected_readings.push_back(typed ? typed_val : pred);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    any_accept = 1'b1;
    case (idx)
      REG_NOM_TEMP: begin
        mir_t0 = int'($signed(val[TEMP_W-1:0]));
      end
      REG_NOM_RES: begin
        mir_r0 = val;
      end
      REG_BETA: begin
        mir_beta = val[BETA_W-1:0];
      end
      default: begin
        mir_rs = val;
      end
    endcase
    refill_window();
    @(negedge clk);
    cfg_write  = 1'b0;
    any_accept = 1'b0;
  endtask

  task automatic configure(input int t0, input int r0, input int b, input int rs);
    logic [TEMP_W-1:0] t0_bits;
    t0_bits = t0[TEMP_W-1:0];
    drain();
    write_reg(REG_NOM_TEMP, {{(CFG_W-TEMP_W){1'b0}}, t0_bits});
    write_reg(REG_NOM_RES, r0[CFG_W-1:0]);
    write_reg(REG_BETA, b[CFG_W-1:0]);
    write_reg(REG_SERIES_RES, rs[CFG_W-1:0]);
  endtask

  // Random code: mostly near a code held in the window, some anywhere, some at the rails.
  function automatic int random_code();
    int sel, c;
    sel = $urandom_range(99);
    if (sel < 65) begin
      c = window_codes[0] + $urandom_range(240) - 120;
      if (c < 0) c = 0;
      if (c > FULL) c = FULL;
    end else if (sel < 88) begin
      c = $urandom_range(FULL);
    end else begin
      c = $urandom_range(1) ? FULL : 0;
    end
    return c;
  endfunction

  typedef struct {
    int       code;
    bit       typed;
    reading_t val;
  } stim_row_t;

  stim_row_t directed [25];

  initial begin
    reading_t blank;
    blank.temp = '0;
    blank.flag = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    adc_sample = '0;
    cfg_write = 1'b0;
    cfg_index = REG_NOM_TEMP;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 1'b0;
    any_accept = 1'b0;
    mismatches = 0;
    mir_t0 = 2500;
    mir_r0 = 10000;
    mir_beta = 4200;
    mir_rs = 10000;
    refill_window();

    // Directed table: a full window of zeros saturates hot, a full window of
    // full-scale codes saturates cold; the rest are checked by the predictor.
    for (int i = 0; i < 25; i++) begin
      directed[i].typed = 1'b0;
      directed[i].val = blank;
    end
    for (int i = 0; i < 8; i++) directed[i].code = 0;
    directed[7].typed = 1'b1;
    directed[7].val.temp = TEMP_MAX;
    directed[7].val.flag = 1'b1;
    for (int i = 8; i < 16; i++) directed[i].code = FULL;
    directed[15].typed = 1'b1;
    directed[15].val.temp = TEMP_MIN;
    directed[15].val.flag = 1'b1;
    directed[16].code = 1;
    directed[17].code = FULL - 1;
    directed[18].code = 511;
    directed[19].code = 512;
    directed[20].code = 10'h155;
    directed[21].code = 10'h2AA;
    directed[22].code = 0;
    directed[23].code = 1;
    directed[24].code = 700;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < 25; i++)
      send_code(directed[i].code, directed[i].typed, directed[i].val);
    for (int i = 0; i < 120; i++) send_code(random_code(), 1'b0, blank);

    for (int ph = 1; ph < 13; ph++) begin
      // Extremes and the reset setting first, then random settings.
      case (ph)
        1: configure(-5500, 1, 1, 1000000);
        2: configure(15000, 1000000, 10000, 1);
        3: configure(2500, 10000, 4200, 10000);
        4: configure(-16384, 0, 0, 0);
        5: configure(16383, 1048575, 16383, 1048575);
        6: configure(0, 1000000, 1, 1000000);
        default: configure($urandom_range(20500) - 5500, $urandom_range(1000000, 1),
                           $urandom_range(10000, 1), $urandom_range(1000000, 1));
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      for (int i = 0; i < 105; i++) begin
        // Long receiver hold-off with the sender running flat out.
        if (ph == 3 && i == 30) begin
          idle_pct = 0;
          hold_request = 1'b1;
        end
        // Sender pause until the pipeline has emptied.
        if (ph == 7 && i == 50) begin
          while (expected_readings.size() != 0) @(negedge clk);
        end
        send_code(random_code(), 1'b0, blank);
      end
    end

    while (expected_readings.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatches == 0) begin
      $display("ntc_thermistor_temperature_top verification clean");
    end else begin
      $display("ntc_thermistor_temperature_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: ntc_thermistor_temperature_top.f
src/ntc_pkg.sv
src/ntc_div.sv
src/ntc_log2.sv
src/ntc_queue.sv
src/ntc_front.sv
src/ntc_back.sv
src/ntc_thermistor_temperature_top.sv
sim/ntc_thermistor_temperature_top_tb.sv
